// File: design/mc3_pkg.sv
// Shared constants, types and the rounding helper of the 3x3 mask convolution.
// Used by mask_convolution_3x3; depends on nothing else.
package mc3_pkg;

    localparam int LINE_DEPTH = 2048;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int COEF_W     = 16;
    localparam int ROWREG_W   = 3 * COEF_W;
    localparam int PROD_W     = PIX_W + 1 + COEF_W;
    localparam int RSUM_W     = PROD_W + 2;
    localparam int SUM_W      = PROD_W + 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(LINE_DEPTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(4096);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_MID    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_BOT    = 3'd4;

    // Reset state: 640 x 480 and the Sobel X mask, left coefficient in the low bits.
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [ROWREG_W-1:0] COEFF_TOP_RESET = 48'h0100_0000_FF00;
    localparam logic [ROWREG_W-1:0] COEFF_MID_RESET = 48'h0200_0000_FE00;
    localparam logic [ROWREG_W-1:0] COEFF_BOT_RESET = 48'h0100_0000_FF00;

    typedef logic [PIX_W-1:0]          pix_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [RSUM_W-1:0]  rsum_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    // Q21.8 sum to pixel: round half to even, then clamp to 0..255.
    function automatic pix_t round_sat(input sum_t sum);
        logic signed [SUM_W-9:0] quo;
        logic [7:0]              rem;
        logic                    inc;
        logic signed [SUM_W-8:0] val;
        pix_t                    res;
        quo = sum[SUM_W-1:8];
        rem = sum[7:0];
        inc = (rem > 8'd128) || ((rem == 8'd128) && quo[0]);
        val = {quo[SUM_W-9], quo} + (SUM_W-7)'(inc);
        if (val < 0) begin
            res = '0;
        end else if (val > (SUM_W-7)'(255)) begin
            res = 8'hFF;
        end else begin
            res = val[7:0];
        end
        return res;
    endfunction

endpackage

// File: design/mask_convolution_3x3.sv
// 3x3 mask convolution over a raster-order 8-bit pixel stream, with two line stores.
// Depends on mc3_pkg for widths, register indexes, reset values and rounding.
// An accepted pixel passes stage 1, the window, product and row-sum stages and the output register.
// Throughput: one pixel per cycle; the pipeline advances whenever the output
// register is empty or being taken, so s_ready only drops while a result stalls.
// Reset (aresetn low at a clock edge) clears counters, window, pipeline valids and
// restores 640 x 480 with the Sobel X mask; the line stores are not cleared.
module mask_convolution_3x3 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mc3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mc3_pkg::ROWREG_W-1:0]  cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mc3_pkg::PIX_W-1:0]     s_pixel_in,
    input  logic                          s_frame_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mc3_pkg::PIX_W-1:0]     m_pixel_out,
    output logic [mc3_pkg::ROW_W-1:0]     m_out_row,
    output logic [mc3_pkg::COL_W-1:0]     m_out_col,
    output logic                          m_frame_last
);

    // Configuration registers.
    logic [mc3_pkg::WIDTH_W-1:0]  width_reg;
    logic [mc3_pkg::HEIGHT_W-1:0] height_reg;
    logic [mc3_pkg::ROWREG_W-1:0] coef_row_reg [3];

    // Position of the next pixel.
    logic [mc3_pkg::ROW_W-1:0] row_count_reg;
    logic [mc3_pkg::COL_W-1:0] col_count_reg;

    // Line stores: A holds the previous row, B the one before it.
    logic [mc3_pkg::PIX_W-1:0] line_a_mem [mc3_pkg::LINE_DEPTH];
    logic [mc3_pkg::PIX_W-1:0] line_b_mem [mc3_pkg::LINE_DEPTH];
    logic [mc3_pkg::PIX_W-1:0] line_a_q_reg;
    logic [mc3_pkg::PIX_W-1:0] line_b_q_reg;
    logic                      fwd_reg;
    logic [mc3_pkg::PIX_W-1:0] fwd_a_reg;
    logic [mc3_pkg::PIX_W-1:0] fwd_b_reg;

    // Stage 1: accepted pixel waiting for its line store data.
    logic                      s1_valid_reg;
    logic [mc3_pkg::PIX_W-1:0] s1_pix_reg;
    logic [mc3_pkg::COL_W-1:0] s1_col_reg;
    logic                      s1_emit_reg;
    logic                      s1_last_reg;
    logic [mc3_pkg::ROW_W-1:0] s1_orow_reg;
    logic [mc3_pkg::COL_W-1:0] s1_ocol_reg;

    // Stage 2: window holds the neighborhood.
    logic [mc3_pkg::PIX_W-1:0] win_reg [9];
    logic [mc3_pkg::PIX_W-1:0] win_next [9];
    logic                      s2_valid_reg;
    logic                      s2_last_reg;
    logic [mc3_pkg::ROW_W-1:0] s2_orow_reg;
    logic [mc3_pkg::COL_W-1:0] s2_ocol_reg;

    // Stage 3: products.
    mc3_pkg::prod_t            prod_reg [9];
    logic                      s3_valid_reg;
    logic                      s3_last_reg;
    logic [mc3_pkg::ROW_W-1:0] s3_orow_reg;
    logic [mc3_pkg::COL_W-1:0] s3_ocol_reg;

    // Stage 4: one sum per mask row.
    mc3_pkg::rsum_t            rsum_reg [3];
    logic                      s4_valid_reg;
    logic                      s4_last_reg;
    logic [mc3_pkg::ROW_W-1:0] s4_orow_reg;
    logic [mc3_pkg::COL_W-1:0] s4_ocol_reg;

    // Output register.
    logic                      m_valid_reg;
    logic [mc3_pkg::PIX_W-1:0] m_pix_reg;
    logic [mc3_pkg::ROW_W-1:0] m_row_reg;
    logic [mc3_pkg::COL_W-1:0] m_col_reg;
    logic                      m_last_reg;

    logic                         adv;
    logic                         accept;
    logic [mc3_pkg::WIDTH_W-1:0]  w_eff;
    logic [mc3_pkg::HEIGHT_W-1:0] h_eff;
    logic [mc3_pkg::ROW_W-1:0]    row_cur;
    logic [mc3_pkg::COL_W-1:0]    col_cur;
    logic [mc3_pkg::WIDTH_W-1:0]  col_inc;
    logic [mc3_pkg::HEIGHT_W-1:0] row_inc;
    logic [mc3_pkg::ROW_W-1:0]    row_count_next;
    logic [mc3_pkg::COL_W-1:0]    col_count_next;
    logic                         emit;
    logic                         last;
    logic [mc3_pkg::PIX_W-1:0]    up1;
    logic [mc3_pkg::PIX_W-1:0]    up2;
    mc3_pkg::sum_t                total;

    // The whole pipeline moves together when the output slot is free or being taken.
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign accept    = s_valid && adv;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (width_reg < mc3_pkg::WIDTH_MIN) begin
            w_eff = mc3_pkg::WIDTH_MIN;
        end else if (width_reg > mc3_pkg::WIDTH_MAX) begin
            w_eff = mc3_pkg::WIDTH_MAX;
        end else begin
            w_eff = width_reg;
        end
        if (height_reg < mc3_pkg::HEIGHT_MIN) begin
            h_eff = mc3_pkg::HEIGHT_MIN;
        end else if (height_reg > mc3_pkg::HEIGHT_MAX) begin
            h_eff = mc3_pkg::HEIGHT_MAX;
        end else begin
            h_eff = height_reg;
        end
    end

    // Position bookkeeping at accept time.
    always_comb begin
        row_cur = s_frame_start ? '0 : row_count_reg;
        col_cur = s_frame_start ? '0 : col_count_reg;
        emit = (row_cur >= mc3_pkg::ROW_W'(2)) && ({1'b0, row_cur} < h_eff)
            && (col_cur >= mc3_pkg::COL_W'(2)) && ({1'b0, col_cur} < w_eff);
        last = ({1'b0, row_cur} == h_eff - 1'b1) && ({1'b0, col_cur} == w_eff - 1'b1);
        col_inc = {1'b0, col_cur} + 1'b1;
        row_inc = {1'b0, row_cur} + 1'b1;
        if (col_inc >= w_eff) begin
            col_count_next = '0;
            if (row_inc >= h_eff) begin
                row_count_next = '0;
            end else begin
                row_count_next = row_inc[mc3_pkg::ROW_W-1:0];
            end
        end else begin
            col_count_next = col_inc[mc3_pkg::COL_W-1:0];
            row_count_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg       <= mc3_pkg::WIDTH_RESET;
            height_reg      <= mc3_pkg::HEIGHT_RESET;
            coef_row_reg[0] <= mc3_pkg::COEFF_TOP_RESET;
            coef_row_reg[1] <= mc3_pkg::COEFF_MID_RESET;
            coef_row_reg[2] <= mc3_pkg::COEFF_BOT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                mc3_pkg::CFG_IMAGE_WIDTH: begin
                    width_reg <= cfg_data[mc3_pkg::WIDTH_W-1:0];
                end
                mc3_pkg::CFG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_data[mc3_pkg::HEIGHT_W-1:0];
                end
                mc3_pkg::CFG_COEFF_TOP: begin
                    coef_row_reg[0] <= cfg_data;
                end
                mc3_pkg::CFG_COEFF_MID: begin
                    coef_row_reg[1] <= cfg_data;
                end
                mc3_pkg::CFG_COEFF_BOT: begin
                    coef_row_reg[2] <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end else if (accept) begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // Stage 1 writes back the column it read when its pixel was accepted. If the new pixel
    // reads that same column, the write is not yet visible, so it is forwarded.
    assign up1 = fwd_reg ? fwd_a_reg : line_a_q_reg;
    assign up2 = fwd_reg ? fwd_b_reg : line_b_q_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            line_a_q_reg <= line_a_mem[col_cur];
            line_b_q_reg <= line_b_mem[col_cur];
            fwd_reg      <= s1_valid_reg && (col_cur == s1_col_reg);
            fwd_a_reg    <= s1_pix_reg;
            fwd_b_reg    <= up1;
        end
        if (adv && s1_valid_reg) begin
            line_a_mem[s1_col_reg] <= s1_pix_reg;
            line_b_mem[s1_col_reg] <= up1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= s_pixel_in;
            s1_col_reg  <= col_cur;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_orow_reg <= row_cur - 1'b1;
            s1_ocol_reg <= col_cur - 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[3*i]     = win_reg[3*i + 1];
            win_next[3*i + 1] = win_reg[3*i + 2];
        end
        win_next[2] = up2;
        win_next[5] = up1;
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (adv && s1_valid_reg) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_last_reg <= s1_last_reg;
            s2_orow_reg <= s1_orow_reg;
            s2_ocol_reg <= s1_ocol_reg;
            for (int k = 0; k < 9; k++) begin
                prod_reg[k] <= $signed({1'b0, win_reg[k]})
                    * $signed(coef_row_reg[k / 3][mc3_pkg::COEF_W*(k % 3) +: mc3_pkg::COEF_W]);
            end
            s3_last_reg <= s2_last_reg;
            s3_orow_reg <= s2_orow_reg;
            s3_ocol_reg <= s2_ocol_reg;
            for (int i = 0; i < 3; i++) begin
                rsum_reg[i] <= mc3_pkg::RSUM_W'(prod_reg[3*i])
                    + mc3_pkg::RSUM_W'(prod_reg[3*i + 1])
                    + mc3_pkg::RSUM_W'(prod_reg[3*i + 2]);
            end
            s4_last_reg <= s3_last_reg;
            s4_orow_reg <= s3_orow_reg;
            s4_ocol_reg <= s3_ocol_reg;
            m_pix_reg   <= mc3_pkg::round_sat(total);
            m_row_reg   <= s4_orow_reg;
            m_col_reg   <= s4_ocol_reg;
            m_last_reg  <= s4_last_reg;
        end
    end

    assign total = mc3_pkg::SUM_W'(rsum_reg[0]) + mc3_pkg::SUM_W'(rsum_reg[1])
                 + mc3_pkg::SUM_W'(rsum_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pix_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_frame_last = m_last_reg;

    // A result is always centered away from the top and left border.
    a_center_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_row_reg != '0) && (m_col_reg != '0))
        else $error("result centered on the top or left border");

    // A stalled output freezes the pending stage 1 item and its column.
    a_stage1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("stage 1 item moved during a stall");

    // Only border-free items travel past the window stage.
    a_emit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && s1_valid_reg && !s1_emit_reg |=> !s2_valid_reg)
        else $error("border pixel entered the arithmetic stages");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && !s1_valid_reg)
        else $error("pipeline not empty after reset");

endmodule

// File: tb/tb_mask_convolution_3x3.sv
// Self-checking testbench for mask_convolution_3x3: a cycle-free predictor follows the
// accepted pixel items and every result item is compared in order with its prediction.
// Depends on mc3_pkg and the mask_convolution_3x3 RTL only.
module tb_mask_convolution_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        mc3_pkg::pix_t             pixel;
        logic [mc3_pkg::ROW_W-1:0] row;
        logic [mc3_pkg::COL_W-1:0] col;
        logic                      last;
    } filt_result_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          cfg_valid     = 1'b0;
    logic                          cfg_ready;
    logic [mc3_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [mc3_pkg::ROWREG_W-1:0]  cfg_data      = '0;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    mc3_pkg::pix_t                 s_pixel_in    = '0;
    logic                          s_frame_start = 1'b0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    mc3_pkg::pix_t                 m_pixel_out;
    logic [mc3_pkg::ROW_W-1:0]     m_out_row;
    logic [mc3_pkg::COL_W-1:0]     m_out_col;
    logic                          m_frame_last;

    // Predictor state: configuration, line stores, window and raster position.
    logic [mc3_pkg::WIDTH_W-1:0]  cfg_width;
    logic [mc3_pkg::HEIGHT_W-1:0] cfg_height;
    logic [mc3_pkg::ROWREG_W-1:0] mask_rows[3];
    mc3_pkg::pix_t                line_prev[mc3_pkg::LINE_DEPTH];
    mc3_pkg::pix_t                line_prev2[mc3_pkg::LINE_DEPTH];
    mc3_pkg::pix_t                win[9];
    int                           pos_row;
    int                           pos_col;

    filt_result_t filtered_q[$];
    filt_result_t want;
    int           mismatch_cnt = 0;
    int           pixels_sent  = 0;
    bit           idle_on      = 1'b0;
    int           hold_req     = 0;
    int           rx_stall     = 0;

    mask_convolution_3x3 i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_frame_last  (m_frame_last)
    );

    always #6 aclk = ~aclk;

    function automatic int eff_width();
        int w;
        w = int'(cfg_width);
        if (w < int'(mc3_pkg::WIDTH_MIN)) w = int'(mc3_pkg::WIDTH_MIN);
        if (w > int'(mc3_pkg::WIDTH_MAX)) w = int'(mc3_pkg::WIDTH_MAX);
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(cfg_height);
        if (h < int'(mc3_pkg::HEIGHT_MIN)) h = int'(mc3_pkg::HEIGHT_MIN);
        if (h > int'(mc3_pkg::HEIGHT_MAX)) h = int'(mc3_pkg::HEIGHT_MAX);
        return h;
    endfunction

    function automatic logic [mc3_pkg::COEF_W-1:0] rand_coeff();
        case ($urandom_range(0, 3))
            0: return mc3_pkg::COEF_W'($urandom_range(0, 1023)) - 16'd512;
            1: return mc3_pkg::COEF_W'($urandom);
            2: return '0;
            default: return (mc3_pkg::COEF_W'($urandom_range(0, 4)) - 16'd2) << 8;
        endcase
    endfunction

    function automatic logic [mc3_pkg::ROWREG_W-1:0] rand_mask_row();
        return {rand_coeff(), rand_coeff(), rand_coeff()};
    endfunction

    task automatic reset_predictor();
        cfg_width    = mc3_pkg::WIDTH_RESET;
        cfg_height   = mc3_pkg::HEIGHT_RESET;
        mask_rows[0] = mc3_pkg::COEFF_TOP_RESET;
        mask_rows[1] = mc3_pkg::COEFF_MID_RESET;
        mask_rows[2] = mc3_pkg::COEFF_BOT_RESET;
        foreach (win[i]) win[i] = '0;
        pos_row = 0;
        pos_col = 0;
    endtask

    // Advances the predictor by one accepted pixel and queues the filtered pixel it yields.
    task automatic convolve_pixel(input mc3_pkg::pix_t pix, input logic fs);
        int                                w, h, r, c;
        mc3_pkg::pix_t                     up1, up2;
        longint                            acc;
        logic signed [mc3_pkg::COEF_W-1:0] k;
        logic [63:0]                       biased, quo;
        longint                            val;
        filt_result_t                      res;
        w = eff_width();
        h = eff_height();
        if (fs) begin
            pos_row = 0;
            pos_col = 0;
        end
        r = pos_row;
        c = pos_col;
        up1 = line_prev[c];
        up2 = line_prev2[c];
        for (int i = 0; i < 3; i++) begin
            win[3*i]   = win[3*i+1];
            win[3*i+1] = win[3*i+2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = pix;
        line_prev2[c] = up1;
        line_prev[c]  = pix;
        if (r >= 2 && r < h && c >= 2 && c < w) begin
            acc = 0;
            for (int rr = 0; rr < 3; rr++) begin
                for (int cc = 0; cc < 3; cc++) begin
                    k = mask_rows[rr][mc3_pkg::COEF_W*cc +: mc3_pkg::COEF_W];
                    acc += longint'(win[3*rr+cc]) * longint'(k);
                end
            end
            // The offset keeps the sum positive so the shift and the parity bit are exact.
            biased = acc + (64'sd1 <<< 40);
            quo = biased >> 8;
            if (biased[7:0] > 8'd128 || (biased[7:0] == 8'd128 && quo[0])) quo++;
            val = longint'(quo) - (64'sd1 <<< 32);
            if (val < 0) res.pixel = '0;
            else if (val > 255) res.pixel = 8'hFF;
            else res.pixel = mc3_pkg::pix_t'(val);
            res.row  = mc3_pkg::ROW_W'(r - 1);
            res.col  = mc3_pkg::COL_W'(c - 1);
            res.last = (r == h - 1) && (c == w - 1);
            filtered_q.push_back(res);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        pos_col = c & 'h7FF;
        pos_row = r & 'hFFF;
    endtask

    task automatic send_pixel(input mc3_pkg::pix_t pix, input logic fs);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_in    <= pix;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        convolve_pixel(pix, fs);
        pixels_sent++;
    endtask

    task automatic send_frame(input int npix);
        for (int i = 0; i < npix; i++) send_pixel(mc3_pkg::pix_t'($urandom), i == 0);
    endtask

    // Waits until every predicted result has arrived and the pipeline has run empty.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mc3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mc3_pkg::ROWREG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            mc3_pkg::CFG_IMAGE_WIDTH:  cfg_width    = data[mc3_pkg::WIDTH_W-1:0];
            mc3_pkg::CFG_IMAGE_HEIGHT: cfg_height   = data[mc3_pkg::HEIGHT_W-1:0];
            mc3_pkg::CFG_COEFF_TOP:    mask_rows[0] = data;
            mc3_pkg::CFG_COEFF_MID:    mask_rows[1] = data;
            mc3_pkg::CFG_COEFF_BOT:    mask_rows[2] = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Bits above the register width carry random noise and must be dropped by the block.
    task automatic write_dims(input int w, input int h);
        logic [mc3_pkg::ROWREG_W-1:0] d;
        d = mc3_pkg::ROWREG_W'({$urandom, $urandom});
        d[mc3_pkg::WIDTH_W-1:0] = mc3_pkg::WIDTH_W'(w);
        write_reg(mc3_pkg::CFG_IMAGE_WIDTH, d);
        d = mc3_pkg::ROWREG_W'({$urandom, $urandom});
        d[mc3_pkg::HEIGHT_W-1:0] = mc3_pkg::HEIGHT_W'(h);
        write_reg(mc3_pkg::CFG_IMAGE_HEIGHT, d);
    endtask

    task automatic write_mask(input logic [mc3_pkg::ROWREG_W-1:0] top,
                              input logic [mc3_pkg::ROWREG_W-1:0] mid,
                              input logic [mc3_pkg::ROWREG_W-1:0] bot);
        write_reg(mc3_pkg::CFG_COEFF_TOP, top);
        write_reg(mc3_pkg::CFG_COEFF_MID, mid);
        write_reg(mc3_pkg::CFG_COEFF_BOT, bot);
    endtask

    // Two rows and a bit at the reset size and mask, starting without a frame marker.
    task automatic test_reset_settings();
        int n;
        n = 2 * int'(mc3_pkg::WIDTH_RESET) + 40;
        for (int i = 0; i < n; i++) send_pixel(mc3_pkg::pix_t'($urandom), 1'b0);
    endtask

    // Shrinks the image while the position counters lie beyond the new size.
    task automatic test_shrunk_dims();
        drain_pipeline();
        write_dims(10, 6);
        for (int i = 0; i < 16; i++) send_pixel(mc3_pkg::pix_t'($urandom), 1'b0);
        drain_pipeline();
        write_dims(10, 4);
        for (int i = 0; i < 45; i++) send_pixel(mc3_pkg::pix_t'($urandom), 1'b0);
    endtask

    task automatic test_value_extremes();
        mc3_pkg::pix_t tie_px[4];
        mc3_pkg::pix_t pix;
        drain_pipeline();
        write_dims(3, 3);
        write_mask({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        for (int idx = int'(mc3_pkg::CFG_COEFF_BOT) + 1; idx < 2**mc3_pkg::CFG_IDX_W; idx++)
            write_reg(mc3_pkg::CFG_IDX_W'(idx), mc3_pkg::ROWREG_W'({$urandom, $urandom}));
        for (int i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);
        drain_pipeline();
        write_mask({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        for (int i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);
        drain_pipeline();
        // Centre weight of one half: odd pixels fall on a tie and must round to even.
        write_dims(6, 3);
        write_mask('0, 48'h0000_0080_0000, '0);
        tie_px = '{8'd1, 8'd3, 8'd255, 8'd2};
        for (int i = 0; i < 18; i++) begin
            pix = (i >= 7 && i <= 10) ? tie_px[i-7] : mc3_pkg::pix_t'($urandom);
            send_pixel(pix, i == 0);
        end
    endtask

    // Dimensions below the minimum are raised to three rows and three columns.
    task automatic test_dim_clamps();
        drain_pipeline();
        write_dims(1, 2);
        write_mask(rand_mask_row(), rand_mask_row(), rand_mask_row());
        send_frame(9);
        drain_pipeline();
        write_dims(0, 0);
        send_frame(9);
    endtask

    // The receiver stops for a long stretch while items keep coming, so the input stalls.
    task automatic test_backpressure();
        drain_pipeline();
        write_dims(12, 6);
        write_mask(rand_mask_row(), rand_mask_row(), rand_mask_row());
        idle_on  = 1'b0;
        hold_req = 300;
        send_frame(72);
        drain_pipeline();
    endtask

    task automatic test_random_frames(input int target);
        int first, w, h, cut, raw_w, raw_h;
        first = pixels_sent;
        while (pixels_sent - first < target) begin
            drain_pipeline();
            case ($urandom_range(0, 9))
                0: raw_w = $urandom_range(0, 2);
                1: raw_w = $urandom_range(13, 40);
                default: raw_w = $urandom_range(3, 12);
            endcase
            raw_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            write_dims(raw_w, raw_h);
            if ($urandom_range(0, 1)) write_reg(mc3_pkg::CFG_COEFF_TOP, rand_mask_row());
            if ($urandom_range(0, 1)) write_reg(mc3_pkg::CFG_COEFF_MID, rand_mask_row());
            if ($urandom_range(0, 1)) write_reg(mc3_pkg::CFG_COEFF_BOT, rand_mask_row());
            w = eff_width();
            h = eff_height();
            repeat ($urandom_range(1, 3)) begin
                cut = w * h;
                if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, w * h - 1);
                // A rare frame marker in mid-frame restarts the raster from the top.
                for (int i = 0; i < cut; i++)
                    send_pixel(mc3_pkg::pix_t'($urandom),
                               (i == 0) || ($urandom_range(0, 199) == 0));
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 8)) send_pixel(mc3_pkg::pix_t'($urandom), 1'b0);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req > 0) begin
            rx_stall = hold_req;
            hold_req = 0;
        end else if (rx_stall == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall = $urandom_range(1, 4);
        end
        if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (filtered_q.size() == 0) begin
                $error("result item with none predicted: row %0d col %0d", m_out_row, m_out_col);
                mismatch_cnt++;
            end else begin
                want = filtered_q.pop_front();
                check_field("pixel_out", want.pixel, m_pixel_out);
                check_field("out_row", want.row, m_out_row);
                check_field("out_col", want.col, m_out_col);
                check_field("frame_last", want.last, m_frame_last);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        reset_predictor();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;
        test_reset_settings();
        test_shrunk_dims();
        test_value_extremes();
        test_dim_clamps();
        test_backpressure();
        idle_on = 1'b1;
        test_random_frames(200);
        idle_on = 1'b0;
        test_random_frames(100);
        drain_pipeline();
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
